// ===== design/fwdw_pkg.sv =====
package fwdw_pkg;

    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int LEN_W      = 4;
    localparam int CHAR_W     = 8;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

    // commands from the sequencer to the bcd converter
    typedef struct packed {
        logic load;
        logic shift_digit;
    } t_bcd_cmd;

endpackage

// ===== design/fwdw_bcd.sv =====
module fwdw_bcd
    import fwdw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_bcd_cmd           i_cmd,
    input  logic [VALUE_W-1:0] i_bin,
    output logic               o_busy,
    output logic [DIGIT_W-1:0] o_top_digit
);

    logic [VALUE_W-1:0]   r_bin;
    logic [BCD_W-1:0]     r_bcd;
    logic [BIT_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic [BCD_W-1:0]     n_adj;

    // add-3 correction on every digit of five or more
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                n_adj[i*DIGIT_W +: DIGIT_W] = r_bcd[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end else begin
                n_adj[i*DIGIT_W +: DIGIT_W] = r_bcd[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.load) begin
            r_bin  <= i_bin;
            r_bcd  <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_bcd <= {n_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
            r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
            r_cnt <= r_cnt + BIT_CNT_W'(1);
            if (r_cnt == BIT_CNT_W'(VALUE_W - 1)) begin
                r_busy <= 1'b0;
            end
        end else if (i_cmd.shift_digit) begin
            r_bcd <= {r_bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        end
    end

    assign o_busy      = r_busy;
    assign o_top_digit = r_bcd[BCD_W-1 -: DIGIT_W];

endmodule

// ===== design/fixed_width_decimal_writer.sv =====
// fixed-width decimal writer
//
// input channel (i_in_valid / o_in_ready): one transaction carries i_func
// (0 unsigned, 1 signed), i_value and i_field_length. the block takes one
// transaction at a time; o_in_ready is high only while it is idle.
// output channel (o_out_valid / i_out_ready): a run of result transactions
// per input, each with o_out_char, o_char_valid, o_ok and o_last. signed
// mode sends '+' or '-' first, then field_length-1 (at least one) digits,
// zero-padded, most significant first. a failing input ends its run with
// one result that has no character, o_ok=0 and o_last=1.
// conversion: a shift-and-add-3 converter takes the value one bit per cycle,
// then unused leading digits are dropped one per cycle and digits leave
// one per cycle while the output stage is free. a too-wide value fails
// once a nonzero digit is found above the field, too-large lengths fail
// without waiting for the converter; the next item can be accepted once
// its last result is in the output stage, even before that result is taken.
// a registered output stage holds the result while the receiver stalls;
// before loading a result, the sequencer waits until that stage is free.
// reset (synchronous, active low) returns to idle and empties the output.
module fixed_width_decimal_writer
    import fwdw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_func,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [LEN_W-1:0]   i_field_length,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [CHAR_W-1:0]  o_out_char,
    output logic               o_char_valid,
    output logic               o_ok,
    output logic               o_last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIGN,
        ST_CONV,
        ST_ALIGN,
        ST_EMIT,
        ST_FAIL
    } t_state;

    t_state             r_state;
    logic               r_neg;
    logic               r_fail;
    logic [LEN_W-1:0]   r_ndig;    // digits to emit, 1..10 for a passing input
    logic [LEN_W-1:0]   r_skip;    // leading digits still to drop
    logic [LEN_W-1:0]   r_left;    // digits still to emit

    logic               r_o_valid;
    logic [CHAR_W-1:0]  r_o_char;
    logic               r_o_char_valid;
    logic               r_o_ok;
    logic               r_o_last;

    logic               w_accept;
    logic               w_out_free;
    logic               w_emit;
    logic [VALUE_W-1:0] w_mag;
    logic [LEN_W-1:0]   w_ulen;
    logic               w_fail;
    t_bcd_cmd           w_cmd;
    logic               w_busy;
    logic [DIGIT_W-1:0] w_top_digit;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_o_valid || i_out_ready;

    // the sequencer loads a new result into the output stage this cycle
    assign w_emit = w_out_free &&
                    ((r_state == ST_SIGN) || (r_state == ST_EMIT) || (r_state == ST_FAIL));

    // magnitude; the most negative value wraps onto 2^31 as unsigned
    assign w_mag = (i_func && i_value[VALUE_W-1]) ? (VALUE_W'(0) - i_value) : i_value;

    // digit count of the unsigned part and early failure
    always_comb begin
        if (i_func) begin
            w_ulen = i_field_length - LEN_W'(1);
            w_fail = (i_field_length == '0) || (w_ulen > LEN_W'(NUM_DIGITS));
        end else begin
            w_ulen = i_field_length;
            w_fail = (w_ulen > LEN_W'(NUM_DIGITS));
        end
    end

    always_comb begin
        w_cmd.load        = w_accept;
        w_cmd.shift_digit = 1'b0;
        unique case (r_state)
            ST_ALIGN: w_cmd.shift_digit = (r_skip != '0) && (w_top_digit == '0);
            ST_EMIT:  w_cmd.shift_digit = w_out_free;
            default:  w_cmd.shift_digit = 1'b0;
        endcase
    end

    fwdw_bcd u_bcd (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_bin       (w_mag),
        .o_busy      (w_busy),
        .o_top_digit (w_top_digit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            // output stage drains when taken and nothing new is loaded
            if (r_o_valid && i_out_ready && !w_emit) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_neg  <= i_func && i_value[VALUE_W-1];
                        r_fail <= w_fail;
                        r_ndig <= (w_ulen == '0) ? LEN_W'(1) : w_ulen;
                        if (i_func) begin
                            r_state <= ST_SIGN;
                        end else if (w_fail) begin
                            r_state <= ST_FAIL;
                        end else begin
                            r_state <= ST_CONV;
                        end
                    end
                end
                ST_SIGN: begin
                    if (w_out_free) begin
                        r_o_valid      <= 1'b1;
                        r_o_char       <= r_neg ? CHAR_MINUS : CHAR_PLUS;
                        r_o_char_valid <= 1'b1;
                        r_o_ok         <= 1'b0;
                        r_o_last       <= 1'b0;
                        r_state        <= r_fail ? ST_FAIL : ST_CONV;
                    end
                end
                ST_CONV: begin
                    // converter is already running since acceptance
                    if (!w_busy) begin
                        r_skip  <= LEN_W'(NUM_DIGITS) - r_ndig;
                        r_left  <= r_ndig;
                        r_state <= ST_ALIGN;
                    end
                end
                ST_ALIGN: begin
                    // a nonzero digit above the field means the value is too wide
                    if (r_skip == '0) begin
                        r_state <= ST_EMIT;
                    end else if (w_top_digit != '0) begin
                        r_state <= ST_FAIL;
                    end else begin
                        r_skip <= r_skip - LEN_W'(1);
                    end
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_o_valid      <= 1'b1;
                        r_o_char       <= CHAR_ZERO + CHAR_W'(w_top_digit);
                        r_o_char_valid <= 1'b1;
                        r_o_ok         <= (r_left == LEN_W'(1));
                        r_o_last       <= (r_left == LEN_W'(1));
                        r_left         <= r_left - LEN_W'(1);
                        if (r_left == LEN_W'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_FAIL: begin
                    if (w_out_free) begin
                        r_o_valid      <= 1'b1;
                        r_o_char       <= CHAR_NONE;
                        r_o_char_valid <= 1'b0;
                        r_o_ok         <= 1'b0;
                        r_o_last       <= 1'b1;
                        r_state        <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_o_valid;
    assign o_out_char   = r_o_char;
    assign o_char_valid = r_o_char_valid;
    assign o_ok         = r_o_ok;
    assign o_last       = r_o_last;

endmodule
